FILE: hw/rtl/rvpp_pkg.sv
// Shared constants and types for the RIP version 2 packet parser.
`default_nettype none

package rvpp_pkg;

	localparam int MAX_ENTRIES   = 25;
	localparam int ENTRY_LEN     = 20;
	localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int EIDX_W        = $clog2(ENTRY_LEN);
	localparam int ENTRY_TOTAL_W = 5;
	localparam int ROUTE_W       = 128;
	localparam int TDATA_W       = 144;

	localparam logic [7:0] CMD_REQUEST  = 8'd1;
	localparam logic [7:0] CMD_RESPONSE = 8'd2;
	localparam logic [7:0] RIP_VERSION  = 8'd2;
	localparam logic [7:0] FAMILY_INET  = 8'd2;
	localparam logic [7:0] METRIC_MAX   = 8'd16;

	// byte positions inside one 20-byte route entry
	localparam logic [EIDX_W-1:0] E_FAMILY_HI = EIDX_W'(0);
	localparam logic [EIDX_W-1:0] E_FAMILY_LO = EIDX_W'(1);
	localparam logic [EIDX_W-1:0] E_TAG_HI    = EIDX_W'(2);
	localparam logic [EIDX_W-1:0] E_TAG_LO    = EIDX_W'(3);
	localparam logic [EIDX_W-1:0] E_MASK_0    = EIDX_W'(8);
	localparam logic [EIDX_W-1:0] E_MASK_1    = EIDX_W'(9);
	localparam logic [EIDX_W-1:0] E_MASK_2    = EIDX_W'(10);
	localparam logic [EIDX_W-1:0] E_MASK_3    = EIDX_W'(11);
	localparam logic [EIDX_W-1:0] E_METRIC_0  = EIDX_W'(16);
	localparam logic [EIDX_W-1:0] E_METRIC_1  = EIDX_W'(17);
	localparam logic [EIDX_W-1:0] E_METRIC_2  = EIDX_W'(18);
	localparam logic [EIDX_W-1:0] E_METRIC_3  = EIDX_W'(19);

	typedef enum logic [1:0] {
		ST_RECV,
		ST_READ,
		ST_SEND
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rip_v2_packet_parser.sv
// Top level: byte-serial RIP v2 message parser with route entry buffer.
`default_nettype none

// Packet bytes enter one per cycle on the slave side, starting with the first IPv4
// header byte, tlast on the final byte. Each byte is checked as it arrives: header
// fields by position, entry fields byte by byte while the entry bytes shift into a
// 15-byte shift register; a complete entry inside the IPv4 total length is written
// to a 25-deep, 128-bit route buffer in its last byte's cycle. The slave side is
// held off from the cycle after the last byte until every result of that packet has
// been taken. Then the block sends one result: an invalid verdict, an empty valid
// result, or one result per buffered entry. Each entry result is a registered buffer
// read, then the output beat, plus any master-side stall; a verdict without entries
// is ready the cycle after the last byte.
module rip_v2_packet_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,  // [7:0] byte_value
	input  wire logic                        s_tlast,  // last_byte
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// [0] packet_ok, [2:1] rip_command, [7:3] entry_total, [8] entry_present,
	// [40:9] route_address, [72:41] route_mask, [104:73] next_hop,
	// [136:105] route_metric, [143:137] zero
	output logic [rvpp_pkg::TDATA_W-1:0]     m_tdata,
	output logic                             m_tlast   // final_result
);
	import rvpp_pkg::*;

	state_t state_q, state_nxt;

	logic [15:0]       pos_q, pos_nxt;
	logic [6:0]        off_q, off_nxt;
	logic [15:0]       len_q, len_nxt;
	logic [7:0]        cmd_q, cmd_nxt;
	logic              err_q, err_nxt;
	logic [CNT_W-1:0]  cnt_q, cnt_nxt;
	logic [EIDX_W-1:0] eidx_q, eidx_nxt;
	logic              bad_q, bad_nxt;
	logic              mzero_q, mzero_nxt;
	logic [119:0]      shift_q;

	logic [ROUTE_W-1:0] route_mem [MAX_ENTRIES];
	logic [ROUTE_W-1:0] mem_rd_q;

	logic              ok_q;
	logic [1:0]        ocmd_q;
	logic [CNT_W-1:0]  n_q;
	logic              ent_q;
	logic [IDX_W-1:0]  rd_idx_q;

	logic              s_acc, s_last_acc;
	logic [7:0]        b;
	logic [15:0]       rel;
	logic              wr_en;
	logic              ebyte;
	logic              bad_b, bad_acc, prev_zero;
	logic [7:0]        inv;
	logic              pkt_ok;
	logic [CNT_W-1:0]  pkt_n;
	logic              out_final;
	logic [ROUTE_W-1:0] route;

	assign b          = s_tdata;
	assign s_acc      = s_tvalid && s_tready;
	assign s_last_acc = s_acc && s_tlast;

	// per-byte header and entry checks
	always_comb begin
		pos_nxt   = pos_q;
		off_nxt   = off_q;
		len_nxt   = len_q;
		cmd_nxt   = cmd_q;
		err_nxt   = err_q;
		cnt_nxt   = cnt_q;
		eidx_nxt  = eidx_q;
		bad_nxt   = bad_q;
		mzero_nxt = mzero_q;
		wr_en     = 1'b0;
		ebyte     = 1'b0;
		bad_b     = 1'b0;
		bad_acc   = 1'b0;
		prev_zero = 1'b0;
		inv       = ~b;
		rel       = pos_q - {9'd0, off_q};

		if (pos_q == 16'd0) begin
			off_nxt = {1'b0, b[3:0], 2'b00} + 7'd8;
		end
		if (pos_q == 16'd2) begin
			len_nxt[15:8] = b;
		end
		if (pos_q == 16'd3) begin
			len_nxt[7:0] = b;
		end

		if (pos_q[15:3] != 13'd0 && pos_q >= {9'd0, off_q}) begin
			if (rel == 16'd0) begin
				cmd_nxt = b;
			end else if (rel == 16'd1) begin
				if (b != RIP_VERSION) err_nxt = 1'b1;
			end else if (rel == 16'd2 || rel == 16'd3) begin
				if (b != 8'd0) err_nxt = 1'b1;
				eidx_nxt = E_FAMILY_HI;
			end else begin
				ebyte = 1'b1;
				case (eidx_q)
					E_FAMILY_HI, E_TAG_HI, E_TAG_LO, E_METRIC_0, E_METRIC_1, E_METRIC_2: begin
						bad_b = (b != 8'd0);
					end
					E_FAMILY_LO: begin
						bad_b = !((cmd_q == CMD_REQUEST && b == 8'd0) ||
						          (cmd_q == CMD_RESPONSE && b == FAMILY_INET));
					end
					E_MASK_0, E_MASK_1, E_MASK_2, E_MASK_3: begin
						// once a zero bit is seen every later mask bit must be zero
						prev_zero = (eidx_q == E_MASK_0) ? 1'b0 : mzero_q;
						bad_b     = prev_zero ? (b != 8'd0) : ((inv & (inv + 8'd1)) != 8'd0);
						mzero_nxt = prev_zero || (b != 8'hFF);
					end
					E_METRIC_3: begin
						bad_b = (b == 8'd0) || (b > METRIC_MAX);
					end
					default: begin
						bad_b = 1'b0;
					end
				endcase
				bad_acc  = ((eidx_q == E_FAMILY_HI) ? 1'b0 : bad_q) || bad_b;
				bad_nxt  = bad_acc;
				eidx_nxt = (eidx_q == E_METRIC_3) ? E_FAMILY_HI : eidx_q + EIDX_W'(1);
				if (eidx_q == E_METRIC_3 && ({1'b0, pos_q} + 17'd1) <= {1'b0, len_q}) begin
					err_nxt = err_nxt || bad_acc;
					if (cnt_q < CNT_W'(MAX_ENTRIES)) begin
						wr_en   = 1'b1;
						cnt_nxt = cnt_q + CNT_W'(1);
					end else begin
						err_nxt = 1'b1;
					end
				end
			end
		end

		pos_nxt = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
	end

	// verdict as of the last byte, including that byte's own effect
	always_comb begin
		pkt_ok = !err_nxt && (cmd_nxt == CMD_REQUEST || cmd_nxt == CMD_RESPONSE) &&
		         ({1'b0, len_nxt} <= ({1'b0, pos_q} + 17'd1)) &&
		         (len_nxt >= ({9'd0, off_nxt} + 16'd4));
		pkt_n  = pkt_ok ? cnt_nxt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			off_q   <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			err_q   <= 1'b0;
			cnt_q   <= '0;
			eidx_q  <= '0;
			bad_q   <= 1'b0;
			mzero_q <= 1'b0;
		end else if (s_last_acc) begin
			pos_q   <= '0;
			off_q   <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			err_q   <= 1'b0;
			cnt_q   <= '0;
			eidx_q  <= '0;
			bad_q   <= 1'b0;
			mzero_q <= 1'b0;
		end else if (s_acc) begin
			pos_q   <= pos_nxt;
			off_q   <= off_nxt;
			len_q   <= len_nxt;
			cmd_q   <= cmd_nxt;
			err_q   <= err_nxt;
			cnt_q   <= cnt_nxt;
			eidx_q  <= eidx_nxt;
			bad_q   <= bad_nxt;
			mzero_q <= mzero_nxt;
		end
	end

	// entry bytes shift in from the top; oldest kept byte is entry byte 4
	always_ff @(posedge clk) begin
		if (s_acc && ebyte) begin
			shift_q <= {b, shift_q[119:8]};
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && wr_en) begin
			route_mem[cnt_q[IDX_W-1:0]] <= {b, shift_q};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			mem_rd_q <= route_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q     <= 1'b0;
			ocmd_q   <= '0;
			n_q      <= '0;
			ent_q    <= 1'b0;
			rd_idx_q <= '0;
		end else if (s_last_acc) begin
			ok_q     <= pkt_ok;
			ocmd_q   <= pkt_ok ? cmd_nxt[1:0] : 2'd0;
			n_q      <= pkt_n;
			ent_q    <= (pkt_n != '0);
			rd_idx_q <= '0;
		end else if (state_q == ST_SEND && m_tready && !out_final) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

	assign out_final = ent_q ? ((CNT_W'(rd_idx_q) + CNT_W'(1)) == n_q) : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_RECV: begin
				if (s_last_acc) state_nxt = (pkt_n != '0) ? ST_READ : ST_SEND;
			end
			ST_READ: begin
				state_nxt = ST_SEND;
			end
			ST_SEND: begin
				if (m_tready) state_nxt = out_final ? ST_RECV : ST_READ;
			end
			default: begin
				state_nxt = ST_RECV;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_RECV: begin
				s_tready = 1'b1;
			end
			ST_SEND: begin
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	assign route   = ent_q ? mem_rd_q : '0;
	assign m_tdata = {7'd0, route, ent_q, ENTRY_TOTAL_W'(n_q), ocmd_q, ok_q};
	assign m_tlast = out_final;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count past buffer depth");

	a_hold_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_last_acc |=> !s_tready && (state_q == ST_READ || state_q == ST_SEND))
		else $error("input not held off after last beat");

	a_verdict_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !ent_q) |-> m_tlast)
		else $error("entry-less result not marked final");

	a_ok_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ent_q) |-> ok_q)
		else $error("entry result on invalid packet");

endmodule

`default_nettype wire
